// ===== rtl/core/psrl_pkg.sv =====
// Shared types and constants of the per-source reply rate limiter.
// Used by every module of the limiter. Has no dependencies of its own.
package psrl_pkg;

    localparam int ID_W          = 32;
    localparam int TIME_W        = 48;
    localparam int SLOT_FIELD_W  = 2;
    localparam int DEF_PEER_SLOTS = 4;

    localparam logic [31:0] INTERVAL_RST = 32'd60000;
    localparam logic [31:0] OWN_ID_RST   = 32'd0;

    // Register indexes of the configuration port.
    localparam logic REG_INTERVAL = 1'b0;
    localparam logic REG_OWN_ID   = 1'b1;

    typedef enum logic [1:0] {
        STATUS_ALLOWED    = 2'd0,
        STATUS_SUPPRESSED = 2'd1,
        STATUS_INVALID    = 2'd2
    } status_t;

    typedef struct packed {
        logic [31:0] suppress_ms;
        logic [31:0] own_id;
    } cfg_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] slot;
        status_t                 status;
    } result_t;

endpackage

// ===== rtl/core/per_source_reply_rate_limiter_unit.sv =====
// Top level of the per-source reply rate limiter.
// Depends on psrl_pkg, psrl_regs, psrl_table and psrl_ctrl.
//
//   Channel   Direction  Handshake            Carries
//   s_        in         s_tvalid / s_tready  source_id, now_ms
//   m_        out        m_tvalid / m_tready  status, slot
//   APB       in         psel/penable/pready  suppress interval, own node id
//
// With the m_ side free, a request whose source is taken from slot k (by match
// or as a free slot) is decided once slot k has been checked; one that evicts
// the oldest slot waits until every slot has been checked, and a rejected
// source skips the scan. The wait before the next acceptance is set by the
// slot scan, which reads one table entry per cycle from the peer memory.
// Reset is synchronous and active low and clears the slot valid flags at once,
// so no clearing pass is needed. A stalled m_ side holds the finished result in
// the output register; the next request is only held off if a further result
// is ready behind it.
module per_source_reply_rate_limiter_unit #(
    parameter int PEER_SLOTS = psrl_pkg::DEF_PEER_SLOTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // [31:0] source_id, [79:32] now_ms
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [1:0] status, [3:2] slot, [7:4] zero
);
    import psrl_pkg::*;

    localparam int SLOT_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;

    cfg_t              cfg;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              rd_valid;
    entry_t            rd_entry;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    entry_t            wr_entry;
    result_t           out_result;

    psrl_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The peer table: ids and last-reply times live in memory, valid flags
    // in flip-flops so that reset empties the table at once.
    psrl_table #(
        .PEER_SLOTS (PEER_SLOTS),
        .SLOT_W     (SLOT_W)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_valid (rd_valid),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry)
    );

    // The sequencer handles one request at a time. The table is only written
    // in the decision cycle and the next scan starts after it, so a read never
    // overlaps a pending write to the same slot.
    psrl_ctrl #(
        .PEER_SLOTS (PEER_SLOTS),
        .SLOT_W     (SLOT_W)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_source_id (s_tdata[31:0]),
        .in_now_ms    (s_tdata[79:32]),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_valid     (rd_valid),
        .rd_entry     (rd_entry),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_entry     (wr_entry),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_result   (out_result)
    );

    assign m_tdata = {4'b0000, out_result.slot, out_result.status};

    // Only one request is in flight: acceptance always drops ready.
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another was in flight");

    // The table is never written while the unit can take a new request.
    a_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !s_tready)
        else $error("table written while idle");

    // A result never carries the unused status code.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("result with an undefined status code");

    // A rejected source always reports slot zero.
    a_invalid_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == STATUS_INVALID) |-> (m_tdata[3:2] == 2'b00))
        else $error("rejected source reported a non-zero slot");

endmodule

// ===== rtl/core/psrl_regs.sv =====
// Configuration registers of the rate limiter behind an APB-style port.
// Depends on psrl_pkg.
module psrl_regs (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output psrl_pkg::cfg_t cfg
);
    import psrl_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_stb;

    assign pready = 1'b1;
    assign wr_stb = psel & penable & pwrite & pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_stb) begin
            case (paddr[2])
                REG_INTERVAL: cfg_next.suppress_ms = pwdata;
                REG_OWN_ID:   cfg_next.own_id      = pwdata;
                default:      cfg_next             = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_INTERVAL: prdata = cfg_reg.suppress_ms;
            REG_OWN_ID:   prdata = cfg_reg.own_id;
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.suppress_ms <= INTERVAL_RST;
            cfg_reg.own_id      <= OWN_ID_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/psrl_table.sv =====
// Peer table of the rate limiter: id and last-reply time in a synchronous memory
// with a registered read port, plus a valid flag per slot. Depends on psrl_pkg.
module psrl_table #(
    parameter int PEER_SLOTS = psrl_pkg::DEF_PEER_SLOTS,
    parameter int SLOT_W     = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    output logic              rd_valid,
    output psrl_pkg::entry_t  rd_entry,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  psrl_pkg::entry_t  wr_entry
);
    import psrl_pkg::*;

    entry_t                  mem [PEER_SLOTS];
    entry_t                  rd_entry_reg;
    logic                    rd_valid_reg;
    logic [PEER_SLOTS-1:0]   valid_reg;
    logic [PEER_SLOTS-1:0]   valid_next;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en) begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    // A slot only ever becomes valid; reset is the one thing that clears it.
    always_comb begin
        valid_next = valid_reg;
        if (wr_en) begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_entry = rd_entry_reg;

endmodule

// ===== rtl/core/psrl_ctrl.sv =====
// Request sequencer of the rate limiter: slot scan, reply decision, table
// write-back and the result register. Depends on psrl_pkg.
module psrl_ctrl #(
    parameter int PEER_SLOTS = psrl_pkg::DEF_PEER_SLOTS,
    parameter int SLOT_W     = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  psrl_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [psrl_pkg::ID_W-1:0]     in_source_id,
    input  logic [psrl_pkg::TIME_W-1:0]   in_now_ms,
    output logic                          rd_en,
    output logic [SLOT_W-1:0]             rd_addr,
    input  logic                          rd_valid,
    input  psrl_pkg::entry_t              rd_entry,
    output logic                          wr_en,
    output logic [SLOT_W-1:0]             wr_addr,
    output psrl_pkg::entry_t              wr_entry,
    output logic                          out_valid,
    input  logic                          out_ready,
    output psrl_pkg::result_t             out_result
);
    import psrl_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PEER_SLOTS - 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_RESULT = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [ID_W-1:0]     src_reg, src_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [SLOT_W-1:0]   issue_idx_reg, issue_idx_next;
    logic                issue_more_reg, issue_more_next;
    logic [SLOT_W-1:0]   chk_idx_reg, chk_idx_next;
    logic                chk_pend_reg, chk_pend_next;
    logic [SLOT_W-1:0]   oldest_idx_reg, oldest_idx_next;
    logic [TIME_W-1:0]   oldest_time_reg, oldest_time_next;
    logic [SLOT_W-1:0]   sel_idx_reg, sel_idx_next;
    logic                sel_valid_reg, sel_valid_next;
    logic [TIME_W-1:0]   sel_time_reg, sel_time_next;
    result_t             res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_result_reg, out_result_next;

    logic                accept;
    logic                bad_src;
    logic                hit;
    logic                older;
    logic [TIME_W:0]     elapsed;
    logic                allow;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid & in_ready;
    assign bad_src  = (in_source_id == '0) || (in_source_id == cfg.own_id);

    assign hit   = rd_valid && (rd_entry.id == src_reg);
    assign older = (chk_idx_reg == '0) || (rd_entry.stamp < oldest_time_reg);

    // Elapsed time with a borrow bit: a set top bit means time went backwards.
    assign elapsed = {1'b0, now_reg} - {1'b0, sel_time_reg};
    assign allow   = !sel_valid_reg ||
                     (!elapsed[TIME_W] &&
                      (elapsed[TIME_W-1:0] >= TIME_W'(cfg.suppress_ms)));

    assign rd_en   = (state_reg == S_SCAN) && issue_more_reg;
    assign rd_addr = issue_idx_reg;

    assign wr_en          = (state_reg == S_DECIDE) && allow;
    assign wr_addr        = sel_idx_reg;
    assign wr_entry.id    = src_reg;
    assign wr_entry.stamp = now_reg;

    always_comb begin
        state_next       = state_reg;
        src_next         = src_reg;
        now_next         = now_reg;
        issue_idx_next   = issue_idx_reg;
        issue_more_next  = issue_more_reg;
        chk_idx_next     = chk_idx_reg;
        chk_pend_next    = 1'b0;
        oldest_idx_next  = oldest_idx_reg;
        oldest_time_next = oldest_time_reg;
        sel_idx_next     = sel_idx_reg;
        sel_valid_next   = sel_valid_reg;
        sel_time_next    = sel_time_reg;
        res_next         = res_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_result_next  = out_result_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    src_next        = in_source_id;
                    now_next        = in_now_ms;
                    issue_idx_next  = '0;
                    issue_more_next = 1'b1;
                    if (bad_src) begin
                        res_next.status = STATUS_INVALID;
                        res_next.slot   = '0;
                        state_next      = S_RESULT;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Reads run one slot ahead of the checks.
                if (rd_en) begin
                    chk_pend_next = 1'b1;
                    chk_idx_next  = issue_idx_reg;
                    if (issue_idx_reg == LAST_SLOT) begin
                        issue_more_next = 1'b0;
                    end else begin
                        issue_idx_next = issue_idx_reg + 1'b1;
                    end
                end
                if (chk_pend_reg) begin
                    if (hit) begin
                        sel_idx_next   = chk_idx_reg;
                        sel_valid_next = 1'b1;
                        sel_time_next  = rd_entry.stamp;
                        state_next     = S_DECIDE;
                    end else if (!rd_valid) begin
                        sel_idx_next   = chk_idx_reg;
                        sel_valid_next = 1'b0;
                        state_next     = S_DECIDE;
                    end else if (chk_idx_reg == LAST_SLOT) begin
                        // Table full and no match: evict the oldest slot.
                        sel_idx_next   = older ? chk_idx_reg : oldest_idx_reg;
                        sel_valid_next = 1'b0;
                        state_next     = S_DECIDE;
                    end else if (older) begin
                        oldest_idx_next  = chk_idx_reg;
                        oldest_time_next = rd_entry.stamp;
                    end
                end
                if (state_next != S_SCAN) begin
                    chk_pend_next   = 1'b0;
                    issue_more_next = 1'b0;
                end
            end
            S_DECIDE: begin
                res_next.status = allow ? STATUS_ALLOWED : STATUS_SUPPRESSED;
                res_next.slot   = SLOT_FIELD_W'(sel_idx_reg);
                state_next      = S_RESULT;
            end
            S_RESULT: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next  = 1'b1;
                    out_result_next = res_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            issue_more_reg <= 1'b0;
            chk_pend_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            issue_more_reg <= issue_more_next;
            chk_pend_reg   <= chk_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg         <= src_next;
        now_reg         <= now_next;
        issue_idx_reg   <= issue_idx_next;
        chk_idx_reg     <= chk_idx_next;
        oldest_idx_reg  <= oldest_idx_next;
        oldest_time_reg <= oldest_time_next;
        sel_idx_reg     <= sel_idx_next;
        sel_valid_reg   <= sel_valid_next;
        sel_time_reg    <= sel_time_next;
        res_reg         <= res_next;
        out_result_reg  <= out_result_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

// ===== tb/sv/tb_per_source_reply_rate_limiter_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for per_source_reply_rate_limiter_unit.
// Depends on psrl_pkg and the limiter RTL; predicts each reply and checks it on the m_ stream.
module tb_per_source_reply_rate_limiter_unit;

    import psrl_pkg::*;

    localparam int PEER_SLOTS  = DEF_PEER_SLOTS;
    localparam int POOL_SIZE   = 6;
    localparam int CYCLE_LIMIT = 400_000;

    // Byte addresses of the two registers on the APB port.
    localparam logic [2:0] ADDR_INTERVAL = {REG_INTERVAL, 2'b00};
    localparam logic [2:0] ADDR_OWN_ID   = {REG_OWN_ID, 2'b00};

    // Every input is given a known value from time zero.
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;   // [31:0] source_id, [79:32] now_ms
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [7:0]  m_tdata;         // [1:0] status, [3:2] slot, [7:4] zero

    per_source_reply_rate_limiter_unit #(
        .PEER_SLOTS(PEER_SLOTS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    // Our own picture of the limiter: the register values and the peer table, kept in step
    // with every request that the unit accepts.
    logic [31:0] suppress_ms = INTERVAL_RST;
    logic [31:0] own_id      = OWN_ID_RST;
    logic [31:0] peer_id    [PEER_SLOTS];
    logic [47:0] peer_stamp [PEER_SLOTS];
    logic        peer_valid [PEER_SLOTS];

    // Replies that the table says must come, oldest first.
    result_t pending_replies[$];

    // Traffic shaping: percentage chances of a sender gap and of a receiver stall burst.
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    int unsigned stall_left = 0;

    logic [31:0] id_pool [POOL_SIZE];
    logic [47:0] clock_ms = '0;

    int unsigned mismatches     = 0;
    int unsigned replies_seen   = 0;
    int unsigned allowed_seen   = 0;
    int unsigned suppress_seen  = 0;
    int unsigned rejected_seen  = 0;
    int unsigned evictions      = 0;
    int unsigned settings_used  = 0;
    int unsigned cycle_count    = 0;
    result_t     want;

    initial begin
        for (int i = 0; i < PEER_SLOTS; i++) begin
            peer_id[i]    = '0;
            peer_stamp[i] = '0;
            peer_valid[i] = 1'b0;
        end
    end

    // Works out the reply to one request and updates the table the way the unit must.
    // The scan stops at the first slot that matches or is free; when every slot is taken,
    // the one with the oldest reply time (lowest index on a tie) is handed to the new source
    // and marked not valid, so that the request is always allowed.
    function automatic result_t predict_reply(input logic [31:0] src, input logic [47:0] now);
        result_t r;
        int      pick;
        int      oldest;
        bit      found;
        bit      allow;
        pick   = 0;
        oldest = 0;
        found  = 1'b0;
        r.slot = '0;
        if (src == '0 || src == own_id) begin
            r.status = STATUS_INVALID;
            return r;
        end
        for (int i = 0; i < PEER_SLOTS && !found; i++) begin
            if (peer_id[i] == src) begin
                pick  = i;
                found = 1'b1;
            end else if (!peer_valid[i]) begin
                peer_id[i] = src;
                pick       = i;
                found      = 1'b1;
            end else if (peer_stamp[i] < peer_stamp[oldest]) begin
                oldest = i;
            end
        end
        if (!found) begin
            pick                = oldest;
            peer_id[oldest]     = src;
            peer_valid[oldest]  = 1'b0;
            evictions++;
        end
        // A time that has gone backwards never passes, even with a zero interval.
        allow = !peer_valid[pick] ||
                (now >= peer_stamp[pick] && (now - peer_stamp[pick]) >= {16'b0, suppress_ms});
        if (allow) begin
            peer_valid[pick] = 1'b1;
            peer_stamp[pick] = now;
            r.status = STATUS_ALLOWED;
        end else begin
            r.status = STATUS_SUPPRESSED;
        end
        r.slot = pick[1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] exp);
        $display("MISMATCH at reply %0d: %s, got %0d, expected %0d", replies_seen, what, got, exp);
        mismatches++;
    endtask

    // Receiver: stalls in bursts while stall_pct is non-zero.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Every reply taken off the m_ stream is held against the oldest pending one.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("reply with no request pending", 48'(m_tdata), 48'd0);
            end else begin
                want = pending_replies.pop_front();
                if (m_tdata[1:0] !== want.status)
                    report_mismatch("status", 48'(m_tdata[1:0]), 48'(want.status));
                if (m_tdata[3:2] !== want.slot)
                    report_mismatch("slot", 48'(m_tdata[3:2]), 48'(want.slot));
                if (m_tdata[7:4] !== 4'b0)
                    report_mismatch("padding bits", 48'(m_tdata[7:4]), 48'd0);
                case (want.status)
                    STATUS_ALLOWED:    allowed_seen++;
                    STATUS_SUPPRESSED: suppress_seen++;
                    default:           rejected_seen++;
                endcase
            end
            replies_seen++;
        end
    end

    // Watchdog: a hung handshake ends the run rather than letting it spin.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d replies pending", cycle_count,
                     pending_replies.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Offers one request and waits for it to be taken. The valid line is left high on
    // return, so that a request that follows at once is not preceded by a spurious low
    // within the same time step; a gap lowers it first instead.
    task automatic send_request(input logic [31:0] src, input logic [47:0] now);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, src};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_replies.push_back(predict_reply(src, now));
    endtask

    // Holds off the sender until every pending reply has come back, the unit is ready
    // again and the receiver has finished any stall burst.
    task automatic wait_for_quiet();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_replies.size() != 0 || !s_tready || stall_left != 0 || !m_tready)
            @(posedge aclk);
    endtask

    // One APB write: a setup phase, then an access phase; pready is always high. The bus
    // then rests idle before the task returns, so that writes in a row never collide.
    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_INTERVAL)
            suppress_ms = value;
        else if (addr == ADDR_OWN_ID)
            own_id = value;
        settings_used++;
        @(posedge aclk);
    endtask

    task automatic configure(input logic [31:0] interval, input logic [31:0] own);
        wait_for_quiet();
        write_register(ADDR_INTERVAL, interval);
        write_register(ADDR_OWN_ID, own);
    endtask

    // Source ids for random traffic: mostly a small pool so that slots are reused and
    // evicted, with some zero ids, some of our own id and some entirely random ones.
    function automatic logic [31:0] pick_source();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 32'd0;
        if (r < 10)
            return own_id;
        if (r < 15)
            return $urandom;
        return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Next timestamp: mostly steps around the suppress interval, hitting it exactly and
    // one short of it, with some repeats, some steps backwards and some random jumps.
    function automatic logic [47:0] next_time(input logic [47:0] t);
        logic [47:0] span;
        logic [63:0] wide;
        int unsigned r;
        r    = $urandom_range(0, 99);
        span = (suppress_ms == '0) ? 48'd4 : {16'b0, suppress_ms};
        if (r < 4) begin
            wide = {$urandom, $urandom};
            return wide[47:0];
        end
        if (r < 9)
            return t - 48'($urandom_range(1, 500));
        if (r < 20)
            return t + span;
        if (r < 30)
            return t + span - 48'd1;
        if (r < 38)
            return t;
        return t + (span * 48'($urandom_range(0, 8))) / 48'd4 + 48'($urandom_range(0, 3));
    endfunction

    // A zero id is always refused, and so is our own id once it is set.
    task automatic test_rejected_sources();
        configure(INTERVAL_RST, OWN_ID_RST);
        send_request(32'd0, 48'd1000);
        configure(INTERVAL_RST, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 48'd1000);
        send_request(32'd0, 48'd2000);
    endtask

    // Fills the four slots in order, then repeats a source one short of the interval and
    // exactly at it, and another source with a time before its last reply.
    task automatic test_slot_fill_and_interval();
        send_request(32'h0000_0001, 48'd100);
        send_request(32'h8000_0000, 48'd200);
        send_request(32'h1234_5678, 48'd300);
        send_request(32'hFFFF_FFFE, 48'd400);
        send_request(32'h0000_0001, 48'd100 + 48'd59999);
        send_request(32'h0000_0001, 48'd100 + 48'd60000);
        send_request(32'h8000_0000, 48'd150);
    endtask

    // A fifth source takes the slot with the oldest reply; with all times equal the lowest
    // slot goes.
    task automatic test_eviction_order();
        send_request(32'h0F0F_0F0F, 48'd70000);
        configure(32'd0, 32'hFFFF_FFFF);
        send_request(32'h0000_0001, 48'd90000);
        send_request(32'h0F0F_0F0F, 48'd90000);
        send_request(32'h1234_5678, 48'd90000);
        send_request(32'hFFFF_FFFE, 48'd90000);
        send_request(32'h0000_0007, 48'd95000);
    endtask

    // With a zero interval an earlier time is still refused; the same time passes.
    task automatic test_time_backwards();
        send_request(32'h0000_0007, 48'd94999);
        send_request(32'h0000_0007, 48'd95000);
    endtask

    // Largest interval and the ends of the time range.
    task automatic test_field_extremes();
        configure(32'hFFFF_FFFF, 32'd0);
        send_request(32'h1234_5678, 48'hFFFF_FFFF_FFFF);
        send_request(32'hFFFF_FFFE, 48'd90000 + 48'hFFFF_FFFE);
        send_request(32'hFFFF_FFFE, 48'd90000 + 48'hFFFF_FFFF);
        send_request(32'h5555_AAAA, 48'd0);
        send_request(32'h5555_AAAA, 48'd0);
    endtask

    task automatic random_stretch(input int unsigned count, input logic [31:0] interval,
                                  input logic [31:0] own, input int unsigned gaps,
                                  input int unsigned stalls);
        gap_pct   = gaps;
        stall_pct = stalls;
        configure(interval, own);
        for (int i = 0; i < POOL_SIZE; i++) begin
            do id_pool[i] = $urandom; while (id_pool[i] == '0);
        end
        for (int n = 0; n < count; n++) begin
            clock_ms = next_time(clock_ms);
            send_request(pick_source(), clock_ms);
        end
    endtask

    // Several register settings in turn, the last one without any idling on either side.
    task automatic test_random_traffic();
        random_stretch(250, 32'd50, $urandom, 30, 25);
        random_stretch(250, 32'd0, 32'd0, 0, 30);
        random_stretch(250, 32'd60000, $urandom, 25, 0);
        random_stretch(250, $urandom, 32'hFFFF_FFFF, 20, 20);
        random_stretch(250, 32'd1000, $urandom, 0, 0);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_rejected_sources();
        test_slot_fill_and_interval();
        test_eviction_order();
        test_time_backwards();
        test_field_extremes();
        test_random_traffic();

        // Drain, then leave room for any stray reply to show itself.
        wait_for_quiet();
        repeat (PEER_SLOTS + 8) @(posedge aclk);
        if (pending_replies.size() != 0)
            report_mismatch("replies never delivered", 48'(pending_replies.size()), 48'd0);

        $display("Covered %0d replies: %0d allowed, %0d suppressed, %0d rejected sources,",
                 replies_seen, allowed_seen, suppress_seen, rejected_seen);
        $display("with %0d slot evictions across %0d register writes; %0d mismatches.",
                 evictions, settings_used, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
